>>> design/sorted_multiset_table_assert.svh
// assertion macros used by the checker file of the sorted multiset table
// depends on nothing; included by bare file name
`ifndef SORTED_MULTISET_TABLE_ASSERT_SVH
`define SORTED_MULTISET_TABLE_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define SMT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("smt assertion failed");

// next-cycle implication, disabled while reset is active
`define SMT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("smt assertion failed");

`endif

>>> design/smt_pkg.sv
// shared types and codes for the sorted multiset table
// no dependencies; used by the top level and the checker
`default_nettype none

package smt_pkg;

	// operation codes carried by the request func field
	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_TEST   = 2'd2,
		FUNC_COUNT  = 2'd3
	} func_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

endpackage

`default_nettype wire

>>> design/smt_in_if.sv
// request channel of the sorted multiset table: valid/ready plus operation payload
// no dependencies
`default_nettype none

interface smt_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic signed [31:0] value;
	logic [6:0]        repeat_count;

	modport source (output valid, func, value, repeat_count, input ready);
	modport sink   (input valid, func, value, repeat_count, output ready);
endinterface

`default_nettype wire

>>> design/smt_out_if.sv
// response channel of the sorted multiset table: valid/ready plus result payload
// no dependencies
`default_nettype none

interface smt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [6:0] occurrences;
	logic [6:0] element_count;

	modport source (output valid, status, occurrences, element_count, input ready);
	modport sink   (input valid, status, occurrences, element_count, output ready);
endinterface

`default_nettype wire

>>> design/sorted_multiset_table.sv
// sorted multiset table: insert, remove, test and count over a sorted value store
// remove/test/count walk the stored entries, a read state and an evaluate state per entry (one memory read port)
// insert walks back from the top, a read and an evaluate state per entry moved, then writes one copy per cycle
// refused or zero-copy inserts go straight to the response state; request ready only when the sequencer is idle
// arst_n clears fill level, order register and handshake state; store contents are not cleared
`default_nettype none

module sorted_multiset_table #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_wr_en,
	input  wire logic  cfg_wr_data,
	smt_in_if.sink     request,
	smt_out_if.source  response
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = ((CW > 7) ? CW : 7) + 1;
	localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EV,
		S_INS_RD,
		S_INS_EV,
		S_FILL,
		S_RESP
	} state_t;

	state_t                  state_q;
	logic                    order_desc_q;
	logic [CW-1:0]           fill_q;
	smt_pkg::func_t          func_q;
	logic signed [VALUE_WIDTH-1:0] val_q;
	logic [6:0]              n_q;
	logic [6:0]              k_q;
	logic [CW-1:0]           ptr_q;
	logic                    found_q;
	logic [CW-1:0]           match_q;
	smt_pkg::status_t        status_q;
	logic [6:0]              occ_q;
	logic                    out_valid_q;
	logic [1:0]              out_status_q;
	logic [6:0]              out_occ_q;
	logic [6:0]              out_cnt_q;

	logic [VALUE_WIDTH-1:0]  mem_q [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] rdata_q;

	logic signed [63:0]      val_ext;
	logic signed [VALUE_WIDTH-1:0] val_in;
	logic [SW-1:0]           need;
	logic                    no_room;
	logic [CW-1:0]           ptr_m1;
	logic [SW-1:0]           shift_addr;
	logic                    goes_before;
	logic                    is_equal;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [VALUE_WIDTH-1:0]  wr_data;

	// incoming value: sign-extend, wrap to the stored width
	assign val_ext = {{32{request.value[31]}}, request.value};
	assign val_in  = val_ext[VALUE_WIDTH-1:0];

	// capacity check for an insert
	assign need    = SW'(fill_q) + SW'(request.repeat_count);
	assign no_room = need > CAP_S;

	// shared compare unit on the entry just read
	assign ptr_m1      = ptr_q - CW'(1);
	assign shift_addr  = SW'(ptr_m1) + SW'(n_q);
	assign goes_before = order_desc_q ? (rdata_q >= val_q) : (rdata_q <= val_q);
	assign is_equal    = rdata_q == val_q;

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q[AW-1:0];
		wr_en   = 1'b0;
		wr_addr = ptr_m1[AW-1:0];
		wr_data = rdata_q;
		unique case (state_q)
			S_SCAN_RD: begin
				rd_en = ptr_q != fill_q;
			end
			S_SCAN_EV: begin
				wr_en = (func_q == smt_pkg::FUNC_REMOVE) && found_q;
			end
			S_INS_RD: begin
				rd_en   = ptr_q != '0;
				rd_addr = ptr_m1[AW-1:0];
			end
			S_INS_EV: begin
				wr_en   = !goes_before;
				wr_addr = shift_addr[AW-1:0];
			end
			S_FILL: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[AW-1:0];
				wr_data = val_q;
			end
			default: begin
			end
		endcase
	end

	// value store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	assign request.ready          = state_q == S_IDLE;
	assign response.valid         = out_valid_q;
	assign response.status        = out_status_q;
	assign response.occurrences   = out_occ_q;
	assign response.element_count = out_cnt_q;

	// sequencer, order register and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			order_desc_q <= 1'b0;
			fill_q       <= '0;
			func_q       <= smt_pkg::FUNC_INSERT;
			val_q        <= '0;
			n_q          <= '0;
			k_q          <= '0;
			ptr_q        <= '0;
			found_q      <= 1'b0;
			match_q      <= '0;
			status_q     <= smt_pkg::ST_OK;
			occ_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_occ_q    <= '0;
			out_cnt_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				order_desc_q <= cfg_wr_data;
			end
			// response register empties on a transfer unless a new result loads
			if (response.ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (request.valid) begin
						func_q   <= smt_pkg::func_t'(request.func);
						val_q    <= val_in;
						n_q      <= request.repeat_count;
						k_q      <= request.repeat_count;
						found_q  <= 1'b0;
						match_q  <= '0;
						occ_q    <= '0;
						if (smt_pkg::func_t'(request.func) == smt_pkg::FUNC_INSERT) begin
							if (no_room) begin
								ptr_q    <= '0;
								status_q <= smt_pkg::ST_FULL;
								state_q  <= S_RESP;
							end else if (request.repeat_count == '0) begin
								ptr_q    <= '0;
								status_q <= smt_pkg::ST_OK;
								state_q  <= S_RESP;
							end else begin
								ptr_q    <= fill_q;
								status_q <= smt_pkg::ST_OK;
								state_q  <= S_INS_RD;
							end
						end else begin
							ptr_q    <= '0;
							status_q <= smt_pkg::ST_OK;
							state_q  <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (ptr_q == fill_q) begin
						status_q <= found_q ? smt_pkg::ST_OK : smt_pkg::ST_NOT_FOUND;
						if (func_q == smt_pkg::FUNC_REMOVE && found_q) begin
							fill_q <= fill_q - CW'(1);
						end
						if (func_q == smt_pkg::FUNC_COUNT) begin
							occ_q <= 7'(match_q);
						end
						state_q <= S_RESP;
					end else begin
						state_q <= S_SCAN_EV;
					end
				end
				S_SCAN_EV: begin
					// after a removal hit the rest only shifts down
					if (!(func_q == smt_pkg::FUNC_REMOVE && found_q) && is_equal) begin
						found_q <= 1'b1;
						match_q <= match_q + CW'(1);
					end
					ptr_q   <= ptr_q + CW'(1);
					state_q <= S_SCAN_RD;
				end
				S_INS_RD: begin
					state_q <= (ptr_q == '0) ? S_FILL : S_INS_EV;
				end
				S_INS_EV: begin
					if (goes_before) begin
						state_q <= S_FILL;
					end else begin
						ptr_q   <= ptr_m1;
						state_q <= S_INS_RD;
					end
				end
				S_FILL: begin
					ptr_q <= ptr_q + CW'(1);
					k_q   <= k_q - 7'd1;
					if (k_q == 7'd1) begin
						fill_q  <= fill_q + CW'(n_q);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || response.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_occ_q    <= occ_q;
						out_cnt_q    <= 7'(fill_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> design/smt_checker.sv
// port-level checks for the sorted multiset table, bound to the top level
// depends on smt_pkg and sorted_multiset_table_assert.svh
`default_nettype none

`include "sorted_multiset_table_assert.svh"

module smt_prop_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_valid,
	input wire logic       req_ready,
	input wire logic       rsp_valid,
	input wire logic       rsp_ready,
	input wire logic [1:0] rsp_status,
	input wire logic [6:0] rsp_occurrences,
	input wire logic [6:0] rsp_element_count
);

	logic [15:0] rsp_payload;
	logic        rsp_stall;
	logic        rsp_miss;

	// response payload as one vector, stall and miss conditions
	assign rsp_payload = {rsp_status, rsp_occurrences, rsp_element_count};
	assign rsp_stall   = rsp_valid && !rsp_ready;
	assign rsp_miss    = rsp_valid && (rsp_status != smt_pkg::ST_OK);

	// a stalled response holds its payload
	`SMT_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_payload))

	// one operation at a time: ready drops after a request transfer
	`SMT_ASSERT_NXT(a_busy_after_req, clk, arst_n, req_valid && req_ready, !req_ready)

	// a nonzero occurrence count only comes with a hit
	`SMT_ASSERT_IMP(a_occ_needs_hit, clk, arst_n, rsp_miss, rsp_occurrences == 7'd0)

endmodule

bind sorted_multiset_table smt_prop_checker u_smt_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (request.valid),
	.req_ready         (request.ready),
	.rsp_valid         (response.valid),
	.rsp_ready         (response.ready),
	.rsp_status        (response.status),
	.rsp_occurrences   (response.occurrences),
	.rsp_element_count (response.element_count)
);

`default_nettype wire
